// ----- rtl/sync_id_crc16_packet_deframer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sync/ID/CRC16 packet deframer
// Each check is compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_ID_CRC16_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define SYNC_ID_CRC16_PACKET_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SPDF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("spdf: property violated");
// condition must never be seen outside reset
`define SPDF_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("spdf: forbidden condition seen");
`else
`define SPDF_ASSERT(lbl, prop)
`define SPDF_NEVER(lbl, cond)
`endif

`endif

// ----- rtl/spdf_pkg.sv -----
// ----------------------------------------------------------------------------
// spdf_pkg
// Types, constants and the CRC byte update shared by the deframer modules.
// ----------------------------------------------------------------------------
package spdf_pkg;

	localparam int unsigned MAX_PACKET_BYTES = 255;
	localparam int unsigned MIN_PACKET_BYTES = 5;
	localparam int unsigned ID_COUNT         = 256;
	localparam int unsigned ID_AW            = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int unsigned QDEPTH           = 2;
	localparam int unsigned QAW              = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam logic [15:0] CRC_POLY_RESET   = 16'hA001;

	typedef enum logic {
		OP_LINK_BYTE = 1'b0,
		OP_FORMAT    = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_GOOD    = 3'd2,
		EV_CRCBAD  = 3'd3,
		EV_UNKNOWN = 3'd4,
		EV_FMT_OK  = 3'd5,
		EV_FMT_REJ = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_ID,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		CFG_SYNC_FIRST  = 2'd0,
		CFG_SYNC_SECOND = 2'd1,
		CFG_CRC_POLY    = 2'd2,
		CFG_CRC_INIT    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] crc_poly;
		logic [15:0] crc_init;
	} cfg_t;

	// classified word as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic [7:0]       rx_byte;
		logic [7:0]       format_id;
		logic [7:0]       format_length;
		logic [ID_AW-1:0] tbl_addr;    // length table address for this word
		logic             addr_ok;     // selected ID lies inside the table
		logic             fmt_len_ok;  // registration length within bounds
	} item_t;

	// reflected CRC16, one byte, LSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
			input logic [7:0] b, input logic [15:0] poly);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/sync_id_crc16_packet_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// sync_id_crc16_packet_deframer_unit
// Two-byte sync packet deframer with per-ID length table and CRC16 check.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | content
//  s_*      | in  | s_tvalid/s_tready   | link byte or format registration
//  m_*      | out | m_tvalid/m_tready   | one event word per input word
//  cfg_*    | in  | cfg_valid/cfg_ready | register index and write data
//
// One word per cycle sustained unless the output stalls; each word passes
// through the queue, the table read and the output register.
// The table is empty right after reset: per-entry valid bits clear at once,
// so no clearing pass is needed. The front queue keeps s_tready high while
// the output is stalled until its two entries fill. cfg_ready is always high.
// ----------------------------------------------------------------------------
module sync_id_crc16_packet_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // rx_byte, format_id, format_length
	input  logic [0:0]  s_tuser,    // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // out_byte, out_packet_id, out_index
	output logic [2:0]  m_tuser,    // event_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	spdf_pkg::cfg_t   cfg_q;
	logic             q_valid;
	spdf_pkg::item_t  q_item;
	logic             q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= '0;
			cfg_q.sync_second <= '0;
			cfg_q.crc_poly    <= spdf_pkg::CRC_POLY_RESET;
			cfg_q.crc_init    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (spdf_pkg::cfg_idx_t'(cfg_index))
				spdf_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data[7:0];
				spdf_pkg::CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data[7:0];
				spdf_pkg::CFG_CRC_POLY:    cfg_q.crc_poly    <= cfg_data;
				spdf_pkg::CFG_CRC_INIT:    cfg_q.crc_init    <= cfg_data;
				default: ;
			endcase
		end
	end

	spdf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	spdf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- rtl/spdf_front.sv -----
// ----------------------------------------------------------------------------
// spdf_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module spdf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // rx_byte, format_id, format_length
	input  logic [0:0]           s_tuser,   // kind
	output logic                 q_valid,
	output spdf_pkg::item_t      q_item,
	input  logic                 q_pop
);

	spdf_pkg::item_t            fifo_q [spdf_pkg::QDEPTH];
	logic [spdf_pkg::QAW-1:0]   wr_ptr_q;
	logic [spdf_pkg::QAW-1:0]   rd_ptr_q;
	logic [spdf_pkg::QAW:0]     cnt_q;
	spdf_pkg::item_t            cls;
	logic                       push;
	logic [7:0]                 sel_id;

	// classify
	always_comb begin
		cls.op            = spdf_pkg::op_t'(s_tuser[0]);
		cls.rx_byte       = s_tdata[7:0];
		cls.format_id     = s_tdata[15:8];
		cls.format_length = s_tdata[23:16];
		sel_id            = (cls.op == spdf_pkg::OP_FORMAT) ? cls.format_id : cls.rx_byte;
		cls.tbl_addr      = sel_id[spdf_pkg::ID_AW-1:0];
		cls.addr_ok       = (32'(sel_id) < spdf_pkg::ID_COUNT);
		cls.fmt_len_ok    = (32'(cls.format_length) <= spdf_pkg::MAX_PACKET_BYTES) &&
			(32'(cls.format_length) >= spdf_pkg::MIN_PACKET_BYTES);
	end

	assign s_tready = (cnt_q != (spdf_pkg::QAW+1)'(spdf_pkg::QDEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == spdf_pkg::QAW'(spdf_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == spdf_pkg::QAW'(spdf_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`include "sync_id_crc16_packet_deframer_unit_assert.svh"

	`SPDF_NEVER(a_q_overfill, cnt_q > (spdf_pkg::QAW+1)'(spdf_pkg::QDEPTH))
	`SPDF_NEVER(a_q_pop_empty, q_pop && (cnt_q == '0))
	`SPDF_ASSERT(a_q_ptrs, (wr_ptr_q == rd_ptr_q) ==
		((cnt_q == '0) || (cnt_q == (spdf_pkg::QAW+1)'(spdf_pkg::QDEPTH))))

endmodule

// ----- rtl/spdf_back.sv -----
// ----------------------------------------------------------------------------
// spdf_back
// Length table, deframer state machine, CRC check and output register.
// ----------------------------------------------------------------------------
module spdf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spdf_pkg::cfg_t       cfg,
	input  logic                 q_valid,
	input  spdf_pkg::item_t      q_item,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // out_byte, out_packet_id, out_index
	output logic [2:0]           m_tuser    // event_res
);

	// length table, valid bit per entry stands for the reset value
	logic [7:0]                     mem [spdf_pkg::ID_COUNT];
	logic [spdf_pkg::ID_COUNT-1:0]  vld_q;

	logic             valid_s1;
	spdf_pkg::item_t  item_s1;
	logic [7:0]       rd_len_s1;
	logic             rd_vld_s1;
	logic             fwd_s1;
	logic [7:0]       fwd_len_s1;

	spdf_pkg::phase_t phase_q, phase_d;
	logic [7:0]       prev_byte_q, prev_byte_d;
	logic             prev_valid_q, prev_valid_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [7:0]       cur_len_q, cur_len_d;
	logic [7:0]       cur_id_q, cur_id_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       crc_hi_q, crc_hi_d;

	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;
	logic [2:0]       m_tuser_q;

	logic             fire;
	logic             link_fire;
	logic             tbl_we;
	logic [7:0]       len_s1;
	logic             fmt_accept;
	logic             sync_hit;
	logic             id_known;
	logic [8:0]       pos_end;
	logic             body_pay;
	logic             body_hi;
	logic [15:0]      crc_in;
	logic [15:0]      crc_fed;
	logic [7:0]       rx;
	spdf_pkg::event_t ev;
	logic [7:0]       ob, oid, oidx;

	assign fire      = valid_s1 && (!m_tvalid_q || m_tready);
	assign link_fire = fire && (item_s1.op == spdf_pkg::OP_LINK_BYTE);
	assign q_pop     = q_valid && (!valid_s1 || fire);
	assign rx        = item_s1.rx_byte;

	// table lookup result, with bypass of a write landing on the same edge as the read
	always_comb begin
		if (!item_s1.addr_ok) begin
			len_s1 = '0;
		end else if (fwd_s1) begin
			len_s1 = fwd_len_s1;
		end else if (rd_vld_s1) begin
			len_s1 = rd_len_s1;
		end else begin
			len_s1 = '0;
		end
	end

	assign fmt_accept = item_s1.fmt_len_ok && item_s1.addr_ok && (len_s1 == '0);
	assign tbl_we     = fire && (item_s1.op == spdf_pkg::OP_FORMAT) && fmt_accept;

	assign sync_hit = prev_valid_q && (prev_byte_q == cfg.sync_first) &&
		(rx == cfg.sync_second);
	assign id_known = (len_s1 != '0);
	assign pos_end  = {1'b0, cnt_q} + 9'd2;
	assign body_pay = (pos_end < {1'b0, cur_len_q});
	assign body_hi  = (pos_end == {1'b0, cur_len_q});
	assign crc_in   = (phase_q == spdf_pkg::PH_HUNT) ? cfg.crc_init : crc_q;
	assign crc_fed  = spdf_pkg::crc_feed(crc_in, rx, cfg.crc_poly);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			spdf_pkg::PH_HUNT: begin
				if (sync_hit) begin
					phase_d = spdf_pkg::PH_ID;
				end
			end
			spdf_pkg::PH_ID: begin
				phase_d = id_known ? spdf_pkg::PH_BODY : spdf_pkg::PH_HUNT;
			end
			spdf_pkg::PH_BODY: begin
				if (!body_pay && !body_hi) begin
					phase_d = spdf_pkg::PH_HUNT;
				end
			end
			default: phase_d = spdf_pkg::PH_HUNT;
		endcase
	end

	// datapath updates and result word
	always_comb begin
		prev_byte_d  = prev_byte_q;
		prev_valid_d = prev_valid_q;
		cnt_d        = cnt_q;
		cur_len_d    = cur_len_q;
		cur_id_d     = cur_id_q;
		crc_d        = crc_q;
		crc_hi_d     = crc_hi_q;
		ev           = spdf_pkg::EV_NONE;
		ob           = '0;
		oid          = '0;
		oidx         = '0;
		if (item_s1.op == spdf_pkg::OP_FORMAT) begin
			oid = item_s1.format_id;
			ev  = fmt_accept ? spdf_pkg::EV_FMT_OK : spdf_pkg::EV_FMT_REJ;
		end else begin
			unique case (phase_q)
				spdf_pkg::PH_HUNT: begin
					if (sync_hit) begin
						cnt_d = 8'd2;
						crc_d = crc_fed;
					end else begin
						prev_byte_d  = rx;
						prev_valid_d = 1'b1;
					end
				end
				spdf_pkg::PH_ID: begin
					cur_id_d = rx;
					if (!id_known) begin
						ev           = spdf_pkg::EV_UNKNOWN;
						oid          = rx;
						prev_valid_d = 1'b0;
						prev_byte_d  = '0;
						cnt_d        = '0;
						cur_len_d    = '0;
					end else begin
						cur_len_d = len_s1;
						crc_d     = crc_fed;
						cnt_d     = 8'd3;
					end
				end
				spdf_pkg::PH_BODY: begin
					oid = cur_id_q;
					if (body_pay) begin
						crc_d = crc_fed;
						ev    = spdf_pkg::EV_PAYLOAD;
						ob    = rx;
						oidx  = cnt_q;
						cnt_d = cnt_q + 1'b1;
					end else if (body_hi) begin
						crc_hi_d = rx;
						cnt_d    = cnt_q + 1'b1;
					end else begin
						ev = ({crc_hi_q, rx} == crc_q) ? spdf_pkg::EV_GOOD
							: spdf_pkg::EV_CRCBAD;
						prev_valid_d = 1'b0;
						prev_byte_d  = '0;
						cnt_d        = '0;
						cur_len_d    = '0;
					end
				end
				default: ;
			endcase
		end
	end

	// stage 1: word from the queue plus registered table read
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1    <= q_item;
			rd_len_s1  <= mem[q_item.tbl_addr];
			rd_vld_s1  <= vld_q[q_item.tbl_addr];
			fwd_s1     <= tbl_we && (item_s1.tbl_addr == q_item.tbl_addr);
			fwd_len_s1 <= item_s1.format_length;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			mem[item_s1.tbl_addr] <= item_s1.format_length;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {oidx, oid, ob};
			m_tuser_q <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			vld_q        <= '0;
			m_tvalid_q   <= 1'b0;
			phase_q      <= spdf_pkg::PH_HUNT;
			prev_byte_q  <= '0;
			prev_valid_q <= 1'b0;
			cnt_q        <= '0;
			cur_len_q    <= '0;
			cur_id_q     <= '0;
			crc_q        <= '0;
			crc_hi_q     <= '0;
		end else begin
			if (!valid_s1 || fire) begin
				valid_s1 <= q_valid;
			end
			if (tbl_we) begin
				vld_q[item_s1.tbl_addr] <= 1'b1;
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (link_fire) begin
				phase_q      <= phase_d;
				prev_byte_q  <= prev_byte_d;
				prev_valid_q <= prev_valid_d;
				cnt_q        <= cnt_d;
				cur_len_q    <= cur_len_d;
				cur_id_q     <= cur_id_d;
				crc_q        <= crc_d;
				crc_hi_q     <= crc_hi_d;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`include "sync_id_crc16_packet_deframer_unit_assert.svh"

	`SPDF_ASSERT(a_body_len, (phase_q == spdf_pkg::PH_BODY) |-> (32'(cur_len_q) >= spdf_pkg::MIN_PACKET_BYTES))
	`SPDF_ASSERT(a_id_count, (phase_q == spdf_pkg::PH_ID) |-> (cnt_q == 8'd2))
	`SPDF_ASSERT(a_tbl_sticky, (vld_q & $past(vld_q)) == $past(vld_q))
	`SPDF_ASSERT(a_pay_index, (m_tvalid_q && (m_tuser_q == spdf_pkg::EV_PAYLOAD)) |-> (m_tdata_q[23:16] >= 8'd3))

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the sync/ID/CRC16 packet deframer
// Streams link bytes and format registrations through the deframer under
// random idling on both sides. A scoreboard object keeps its own copy of the
// deframer state, predicts the event word for every accepted input word and
// checks each output word in order. The run goes through several sync/CRC
// settings, including all-zero and all-one values.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		spdf_pkg::event_t ev;
		logic [7:0]       data_byte;
		logic [7:0]       pkt_id;
		logic [7:0]       pos;
	} deframe_result_t;

	class deframer_checker;
		spdf_pkg::cfg_t   cfg;
		logic [7:0]       prev_byte;
		bit               have_prev;
		spdf_pkg::phase_t rx_phase;
		logic [7:0]       count;
		logic [7:0]       cur_len;
		logic [7:0]       cur_id;
		logic [15:0]      crc;
		logic [7:0]       crc_hi;
		logic [7:0]       len_tbl [spdf_pkg::ID_COUNT];
		deframe_result_t  pending_events [$];
		int unsigned      errors;

		function new();
			cfg.sync_first = 8'h00;
			cfg.sync_second = 8'h00;
			cfg.crc_poly = spdf_pkg::CRC_POLY_RESET;
			cfg.crc_init = 16'h0000;
			errors = 0;
			foreach (len_tbl[i]) len_tbl[i] = 8'h00;
			rehunt();
			cur_id = 8'h00;
			crc = 16'h0000;
			crc_hi = 8'h00;
		endfunction

		function void rehunt();
			rx_phase = spdf_pkg::PH_HUNT;
			have_prev = 1'b0;
			prev_byte = 8'h00;
			count = 8'h00;
			cur_len = 8'h00;
		endfunction

		function void set_reg(spdf_pkg::cfg_idx_t idx, logic [15:0] d);
			case (idx)
				spdf_pkg::CFG_SYNC_FIRST: cfg.sync_first = d[7:0];
				spdf_pkg::CFG_SYNC_SECOND: cfg.sync_second = d[7:0];
				spdf_pkg::CFG_CRC_POLY: cfg.crc_poly = d;
				spdf_pkg::CFG_CRC_INIT: cfg.crc_init = d;
			endcase
		endfunction

		// reflected, LSB first
		function logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
			logic [15:0] c;
			int k;
			c = c_in ^ {8'h00, b};
			for (k = 0; k < 8; k++) begin
				if (c[0]) c = (c >> 1) ^ cfg.crc_poly;
				else c = c >> 1;
			end
			return c;
		endfunction

		function void note_word(spdf_pkg::op_t kind, logic [23:0] data);
			logic [7:0] rx, fid, flen, ln;
			int unsigned pos;
			deframe_result_t r;
			rx = data[7:0];
			fid = data[15:8];
			flen = data[23:16];
			r.ev = spdf_pkg::EV_NONE;
			r.data_byte = 8'h00;
			r.pkt_id = 8'h00;
			r.pos = 8'h00;
			if (kind == spdf_pkg::OP_FORMAT) begin
				r.pkt_id = fid;
				if (flen > spdf_pkg::MAX_PACKET_BYTES || flen < spdf_pkg::MIN_PACKET_BYTES
						|| fid >= spdf_pkg::ID_COUNT || len_tbl[fid] != 8'h00) begin
					r.ev = spdf_pkg::EV_FMT_REJ;
				end else begin
					len_tbl[fid] = flen;
					r.ev = spdf_pkg::EV_FMT_OK;
				end
			end else begin
				case (rx_phase)
					spdf_pkg::PH_HUNT: begin
						if (have_prev && prev_byte == cfg.sync_first
								&& rx == cfg.sync_second) begin
							rx_phase = spdf_pkg::PH_ID;
							count = 8'd2;
							crc = crc_byte(cfg.crc_init, rx);
						end else begin
							prev_byte = rx;
							have_prev = 1'b1;
						end
					end
					spdf_pkg::PH_ID: begin
						cur_id = rx;
						ln = (rx < spdf_pkg::ID_COUNT) ? len_tbl[rx] : 8'h00;
						if (ln == 8'h00) begin
							r.ev = spdf_pkg::EV_UNKNOWN;
							r.pkt_id = rx;
							rehunt();
						end else begin
							cur_len = ln;
							crc = crc_byte(crc, rx);
							count = 8'd3;
							rx_phase = spdf_pkg::PH_BODY;
						end
					end
					default: begin
						r.pkt_id = cur_id;
						pos = count;
						if (pos + 2 < cur_len) begin
							crc = crc_byte(crc, rx);
							r.ev = spdf_pkg::EV_PAYLOAD;
							r.data_byte = rx;
							r.pos = count;
							count = count + 8'd1;
						end else if (pos + 2 == cur_len) begin
							crc_hi = rx;
							count = count + 8'd1;
						end else begin
							r.ev = ({crc_hi, rx} == crc) ? spdf_pkg::EV_GOOD
								: spdf_pkg::EV_CRCBAD;
							rehunt();
						end
					end
				endcase
			end
			pending_events = {pending_events, r};
		endfunction

		function void cmp(string what, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_word(logic [2:0] ev, logic [23:0] data);
			deframe_result_t r;
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event word: event %0d data %h", $time, ev, data);
				errors++;
				return;
			end
			r = pending_events.pop_front();
			cmp("event_res", {5'b0, r.ev}, {5'b0, ev});
			cmp("out_byte", r.data_byte, data[7:0]);
			cmp("out_packet_id", r.pkt_id, data[15:8]);
			cmp("out_index", r.pos, data[23:16]);
		endfunction

		function int unsigned pending();
			return pending_events.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;     // rx_byte, format_id, format_length
	logic [0:0]  s_tuser;     // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;     // out_byte, out_packet_id, out_index
	logic [2:0]  m_tuser;     // event_res
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	deframer_checker chk;
	int unsigned     items_sent;
	bit              quiet;
	bit              hold_request;

	sync_id_crc16_packet_deframer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("sync_id_crc16_packet_deframer_unit regression: fail");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// output side: random stalls plus an occasional long hold-off
	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		m_tready = 1'b0;
		stall_left = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 250;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) chk.check_word(m_tuser, m_tdata);
	end

	task automatic push_word(input spdf_pkg::op_t kind, input logic [23:0] data);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		chk.note_word(kind, data);
		items_sent++;
		@(negedge clk);
	endtask

	// unused fields carry random bits
	task automatic push_link(input logic [7:0] b);
		push_word(spdf_pkg::OP_LINK_BYTE, {16'($urandom_range(0, 65535)), b});
	endtask

	task automatic push_format(input logic [7:0] id, input logic [7:0] len);
		push_word(spdf_pkg::OP_FORMAT, {len, id, 8'($urandom_range(0, 255))});
	endtask

	function automatic logic [7:0] format_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 8'($urandom_range(5, 20));
		if (r < 75) return 8'($urandom_range(0, 4));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] noise_byte();
		int unsigned r;
		r = $urandom_range(0, 3);
		if (r == 0) return chk.cfg.sync_first;
		if (r == 1) return chk.cfg.sync_second;
		return 8'($urandom_range(0, 255));
	endfunction

	// a registered ID, usually of a short packet; -1 if none found
	function automatic int pick_packet_id();
		bit want_long;
		int id, tries;
		logic [7:0] l;
		want_long = ($urandom_range(0, 99) == 0);
		for (tries = 0; tries < 100; tries++) begin
			id = $urandom_range(0, spdf_pkg::ID_COUNT - 1);
			l = chk.len_tbl[id];
			if (l != 8'h00 && ((want_long && l > 40) || (!want_long && l <= 24))) return id;
		end
		return -1;
	endfunction

	// full packet from the current table and settings; cut > 0 truncates it
	task automatic send_packet(input logic [7:0] pid, input bit corrupt,
			input int unsigned cut);
		logic [7:0]  pkt [$];
		logic [15:0] c;
		logic [7:0]  b;
		int unsigned plen, n, k;
		plen = chk.len_tbl[pid];
		pkt = {pkt, chk.cfg.sync_first};
		pkt = {pkt, chk.cfg.sync_second};
		pkt = {pkt, pid};
		c = chk.crc_byte(chk.cfg.crc_init, chk.cfg.sync_second);
		c = chk.crc_byte(c, pid);
		for (k = 3; k + 2 < plen; k++) begin
			b = 8'($urandom_range(0, 255));
			pkt = {pkt, b};
			c = chk.crc_byte(c, b);
		end
		pkt = {pkt, c[15:8]};
		pkt = {pkt, c[7:0]};
		if (corrupt) begin
			k = $urandom_range(3, pkt.size() - 1);
			pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
		end
		n = (cut == 0 || cut > pkt.size()) ? pkt.size() : cut;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 39) == 0)
				push_format(8'($urandom_range(0, 255)), format_len());
			push_link(pkt[k]);
		end
	endtask

	// sender stops until every event word is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (chk.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// 8-bit registers get random upper data bits, which must be dropped
	task automatic write_regs(input logic [7:0] sf, input logic [7:0] ss,
			input logic [15:0] poly, input logic [15:0] init);
		logic [15:0] val [4];
		int i;
		val[0] = {8'($urandom_range(0, 255)), sf};
		val[1] = {8'($urandom_range(0, 255)), ss};
		val[2] = poly;
		val[3] = init;
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= spdf_pkg::cfg_idx_t'(i);
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			chk.set_reg(spdf_pkg::cfg_idx_t'(i), val[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_step();
		int unsigned r;
		int id;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			push_format(8'($urandom_range(0, 255)), format_len());
		end else if (r < 16) begin
			repeat ($urandom_range(1, 6)) push_link(noise_byte());
		end else if (r < 22) begin
			id = pick_packet_id();
			if (id < 0 || $urandom_range(0, 1) == 0) id = $urandom_range(0, 255);
			send_packet(8'(id), 1'b0, $urandom_range(1, 6));
		end else begin
			while (chk.rx_phase != spdf_pkg::PH_HUNT) push_link(8'($urandom_range(0, 255)));
			id = pick_packet_id();
			if (id < 0) push_format(8'($urandom_range(0, 255)), 8'($urandom_range(5, 16)));
			else send_packet(8'(id), $urandom_range(0, 6) == 0, 0);
		end
	endtask

	initial begin
		logic [15:0] c;
		int ph;
		int unsigned phase_end;
		chk = new();
		items_sent = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_regs(8'h7E, 8'h81, 16'hA001, 16'hFFFF);

		// length bounds, duplicate ID, shortest and longest formats
		push_format(8'h00, 8'd4);
		push_format(8'h00, 8'd0);
		push_format(8'h00, 8'd5);
		push_format(8'h00, 8'd9);
		push_format(8'hFF, 8'd255);
		push_format(8'h42, 8'd7);
		// repeated first sync byte, then an empty-payload packet
		push_link(8'h7E);
		send_packet(8'h00, 1'b0, 0);
		// unregistered ID
		push_link(8'h7E);
		push_link(8'h81);
		push_link(8'h13);
		// bad CRC, with a registration in the middle of the packet
		push_link(8'h7E);
		push_link(8'h81);
		push_link(8'h42);
		push_format(8'h10, 8'd8);
		push_link(8'h3C);
		push_link(8'hC3);
		c = chk.crc_byte(chk.crc_byte(chk.cfg.crc_init, 8'h81), 8'h42);
		c = chk.crc_byte(chk.crc_byte(c, 8'h3C), 8'hC3);
		push_link(c[15:8]);
		push_link(c[7:0] ^ 8'h01);

		for (ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: write_regs(8'h00, 8'h00, 16'h0000, 16'h0000);
					2: write_regs(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
					default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
				endcase
			end
			phase_end = (ph + 1) * 1250 / 6;
			quiet = (ph == 2 || ph == 4);
			while (items_sent < phase_end) begin
				random_step();
				if (quiet && items_sent > phase_end - 150) quiet = 1'b0;
				if (ph == 1 && !hold_request && items_sent > 260 && items_sent < 270)
					hold_request = 1'b1;
				if (ph == 3 && items_sent > 700 && items_sent < 710) drain();
			end
			if (ph == 4) begin
				while (chk.rx_phase != spdf_pkg::PH_HUNT)
					push_link(8'($urandom_range(0, 255)));
				send_packet(8'hFF, 1'b0, 0);
			end
		end

		s_tvalid <= 1'b0;
		while (chk.pending() != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0) begin
			$display("sync_id_crc16_packet_deframer_unit regression: pass");
		end else begin
			$display("sync_id_crc16_packet_deframer_unit regression: fail");
		end
		$finish;
	end

endmodule
